/* rtl/core/atl_pkg.sv */
`timescale 1ns / 1ps

package atl_pkg;

  // commands
  localparam logic [2:0] CMD_TRACK   = 3'd0;
  localparam logic [2:0] CMD_UNTRACK = 3'd1;
  localparam logic [2:0] CMD_FIND    = 3'd2;
  localparam logic [2:0] CMD_MARK    = 3'd3;
  localparam logic [2:0] CMD_SCAN    = 3'd4;
  localparam logic [2:0] CMD_STATS   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  // entry states
  localparam logic [2:0] STATE_ALLOCATED = 3'd0;
  localparam logic [2:0] STATE_FREED     = 3'd1;
  localparam logic [2:0] STATE_SUSPECT   = 3'd2;
  localparam logic [2:0] STATE_IGNORED   = 3'd3;
  localparam logic [2:0] STATE_TRACKED   = 3'd4;

  // flag bit positions
  localparam int FLAG_RECURSIVE = 0;
  localparam int FLAG_PERMANENT = 3;

  // event counter slots
  localparam int CNT_ALLOC     = 0;
  localparam int CNT_FREE      = 1;
  localparam int CNT_SUSPECT   = 2;
  localparam int CNT_IGNORED   = 3;
  localparam int CNT_RECURSIVE = 4;
  localparam int CNT_PERMANENT = 5;
  localparam int NUM_COUNTERS  = 6;
  localparam logic [2:0] STATS_LAST = 3'd6;

  // configuration registers
  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;
  localparam logic [5:0]  CAP_RESET = 6'd32;
  localparam logic [31:0] THR_RESET = 32'd3600;

  typedef struct packed {
    logic [47:0] address;
    logic [31:0] size;
    logic [2:0]  kind;
    logic [2:0]  state;
    logic [3:0]  flags;
    logic [31:0] alloc_time;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] address;
    logic [31:0] size;
    logic [2:0]  kind;
    logic [2:0]  state;
    logic [3:0]  flags;
    logic [31:0] lifetime;
    logic [31:0] count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_RESP, S_SHIFT_RD, S_SHIFT_WR,
    S_SCAN_RD, S_SCAN_CMP, S_SUM, S_STATS
  } fsm_t;

endpackage

/* rtl/core/allocation_leak_tracker_table_core.sv */
`timescale 1ns / 1ps

// Ordered allocation table in one memory with a separate read and write port, and a small sequencer.
// One command is taken at a time (s_axis_tready is high only when idle).
// Search-based commands (track, untrack, find, mark) walk the entries in use
// one by one (read, then compare); untrack then compacts the table, reading
// and writing back each moved entry. Scan reads and compares each entry, then
// gives a summary word; stats returns seven words, one per cycle while the
// output register is free. Output words sit in a register and wait for
// m_axis_tready, which can stall any of these commands; the table needs no
// clearing after reset.
module allocation_leak_tracker_table_core import atl_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[2:0] address[50:3] block_size[82:51] alloc_type[85:83]
  // track_flags[89:86] mark_state[92:90] now[124:93]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0] entry_address[50:3] entry_size[82:51] entry_type[85:83]
  // entry_state[88:86] entry_flags[92:89] lifetime[124:93] count_value[156:125]
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (CW > 3) ? CW : 3;

  fsm_t state, state_next;

  logic [5:0]    cap_limit;
  logic [31:0]   threshold;
  logic [CW-1:0] active;
  logic [31:0]   counters [NUM_COUNTERS];
  logic [IW-1:0] idx;
  logic [CW-1:0] hits;

  logic [2:0]  cmd_r;
  logic [47:0] addr_r;
  logic [31:0] size_r;
  logic [2:0]  kind_r;
  logic [3:0]  flags_r;
  logic [2:0]  ns_r;
  logic [31:0] now_r;

  result_t resp;
  result_t out_data;
  logic    out_valid;
  logic    out_last;

  // incoming word
  logic [2:0]  in_cmd;
  logic [47:0] in_addr;
  logic [2:0]  in_ns;
  assign in_cmd  = s_axis_tdata[2:0];
  assign in_addr = s_axis_tdata[50:3];
  assign in_ns   = s_axis_tdata[92:90];

  logic accept, out_free;
  assign s_axis_tready = (state == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  // effective capacity and fullness
  logic [6:0] cap_ext, max_ext, cap_eff;
  logic       full;
  always_comb begin
    cap_ext = {1'b0, cap_limit};
    max_ext = 7'(MAX_ENTRIES);
    cap_eff = (cap_ext > max_ext) ? max_ext : cap_ext;
    full    = 7'(active) >= cap_eff;
  end

  logic [IW:0] idx_p1;
  logic [IW:0] active_ext;
  logic        idx_lt_active, idx_p1_lt_active;
  assign idx_p1           = {1'b0, idx} + 1'b1;
  assign active_ext       = (IW + 1)'(active);
  assign idx_lt_active    = {1'b0, idx} < active_ext;
  assign idx_p1_lt_active = idx_p1 < active_ext;

  // memory port
  logic    mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t  mem_wdata, rd;

  atl_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  logic        hit_addr;
  logic [31:0] age;
  assign hit_addr = (rd.address == addr_r);
  assign age      = now_r - rd.alloc_time;

  function automatic result_t entry_res(input entry_t e, input logic [2:0] st,
                                        input logic [31:0] now);
    result_t r;
    r.status   = ST_OK;
    r.address  = e.address;
    r.size     = e.size;
    r.kind     = e.kind;
    r.state    = st;
    r.flags    = e.flags;
    r.lifetime = now - e.alloc_time;
    r.count    = '0;
    return r;
  endfunction

  function automatic result_t fail_res(input logic [2:0] st);
    result_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd <= CMD_MARK && in_addr == '0) begin
            state_next = S_RESP;
          end else if (in_cmd == CMD_TRACK && full) begin
            state_next = S_RESP;
          end else if (in_cmd <= CMD_MARK) begin
            state_next = S_RD;
          end else if (in_cmd == CMD_SCAN) begin
            state_next = S_SCAN_RD;
          end else if (in_cmd == CMD_STATS) begin
            state_next = S_STATS;
          end
        end
      end
      S_RD:       state_next = idx_lt_active ? S_CMP : S_RESP;
      S_CMP:      state_next = hit_addr ? S_RESP : S_RD;
      S_RESP: begin
        if (out_free) begin
          state_next = (cmd_r == CMD_UNTRACK && resp.status == ST_OK) ? S_SHIFT_RD : S_IDLE;
        end
      end
      S_SHIFT_RD: state_next = idx_p1_lt_active ? S_SHIFT_WR : S_IDLE;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_SCAN_RD:  state_next = idx_lt_active ? S_SCAN_CMP : S_SUM;
      S_SCAN_CMP: begin
        if (age <= threshold || out_free) begin
          state_next = S_SCAN_RD;
        end
      end
      S_SUM:      if (out_free) state_next = S_IDLE;
      S_STATS:    if (out_free && idx[2:0] == STATS_LAST) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // control
  logic        resp_load, emit, emit_last, idx_clr, idx_inc, act_inc, act_dec;
  result_t     resp_val, emit_val;
  logic [NUM_COUNTERS-1:0] bump;
  entry_t      new_entry;

  always_comb begin
    new_entry.address    = addr_r;
    new_entry.size       = size_r;
    new_entry.kind       = kind_r;
    new_entry.state      = STATE_ALLOCATED;
    new_entry.flags      = flags_r;
    new_entry.alloc_time = now_r;
  end

  always_comb begin
    resp_load = 1'b0;
    resp_val  = '0;
    emit      = 1'b0;
    emit_val  = '0;
    emit_last = 1'b0;
    idx_clr   = 1'b0;
    idx_inc   = 1'b0;
    act_inc   = 1'b0;
    act_dec   = 1'b0;
    bump      = '0;
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = rd;
    mem_re    = 1'b0;
    mem_raddr = idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          idx_clr = 1'b1;
          if (in_cmd <= CMD_MARK && in_addr == '0) begin
            resp_load = 1'b1;
            resp_val  = fail_res(ST_ZERO);
          end else if (in_cmd == CMD_TRACK && full) begin
            resp_load = 1'b1;
            resp_val  = fail_res(ST_FULL);
          end
        end
      end
      S_RD: begin
        if (idx_lt_active) begin
          mem_re = 1'b1;
        end else begin
          resp_load = 1'b1;
          if (cmd_r == CMD_TRACK) begin
            // append at the end of the table
            mem_we    = 1'b1;
            mem_waddr = active[AW-1:0];
            mem_wdata = new_entry;
            act_inc   = 1'b1;
            bump[CNT_ALLOC]     = 1'b1;
            bump[CNT_RECURSIVE] = flags_r[FLAG_RECURSIVE];
            bump[CNT_PERMANENT] = flags_r[FLAG_PERMANENT];
            resp_val  = entry_res(new_entry, STATE_ALLOCATED, now_r);
          end else begin
            resp_val  = fail_res(ST_MISSING);
          end
        end
      end
      S_CMP: begin
        if (hit_addr) begin
          resp_load = 1'b1;
          case (cmd_r)
            CMD_TRACK:   resp_val = fail_res(ST_DUP);
            CMD_UNTRACK: resp_val = entry_res(rd, STATE_FREED, now_r);
            CMD_MARK: begin
              mem_we          = 1'b1;
              mem_wdata       = rd;
              mem_wdata.state = ns_r;
              bump[CNT_SUSPECT] = (ns_r == STATE_SUSPECT);
              bump[CNT_IGNORED] = (ns_r == STATE_IGNORED);
              resp_val = entry_res(rd, ns_r, now_r);
            end
            default:     resp_val = entry_res(rd, rd.state, now_r);
          endcase
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_val  = resp;
          emit_last = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (idx_p1_lt_active) begin
          mem_re    = 1'b1;
          mem_raddr = idx_p1[AW-1:0];
        end else begin
          act_dec        = 1'b1;
          bump[CNT_FREE] = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        mem_we  = 1'b1;
        idx_inc = 1'b1;
      end
      S_SCAN_RD: begin
        if (idx_lt_active) begin
          mem_re = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        if (age > threshold) begin
          if (out_free) begin
            emit     = 1'b1;
            emit_val = entry_res(rd, rd.state, now_r);
            idx_inc  = 1'b1;
          end
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_SUM: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_val.count = 32'(hits);
          emit_last      = 1'b1;
        end
      end
      S_STATS: begin
        if (out_free) begin
          emit    = 1'b1;
          idx_inc = 1'b1;
          if (idx[2:0] == STATS_LAST) begin
            emit_val.count = 32'(active);
            emit_last      = 1'b1;
          end else begin
            emit_val.count = counters[idx[2:0]];
          end
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap_limit <= CAP_RESET;
      threshold <= THR_RESET;
      active    <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      idx       <= '0;
      hits      <= '0;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        counters[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) begin
          cap_limit <= cfg_data[5:0];
        end else begin
          threshold <= cfg_data;
        end
      end
      if (act_inc) begin
        active <= active + 1'b1;
      end else if (act_dec) begin
        active <= active - 1'b1;
      end
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        if (bump[k] && counters[k] != '1) begin
          counters[k] <= counters[k] + 32'd1;
        end
      end
      if (idx_clr) begin
        idx  <= '0;
        hits <= '0;
      end else if (idx_inc) begin
        idx <= idx_p1[IW-1:0];
        if (state == S_SCAN_CMP && emit) begin
          hits <= hits + 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_last  <= emit_last;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_addr;
      size_r  <= s_axis_tdata[82:51];
      kind_r  <= s_axis_tdata[85:83];
      flags_r <= s_axis_tdata[89:86];
      ns_r    <= (in_ns > STATE_TRACKED) ? STATE_TRACKED : in_ns;
      now_r   <= s_axis_tdata[124:93];
    end
    if (resp_load) begin
      resp <= resp_val;
    end
    if (emit) begin
      out_data <= emit_val;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {3'b000, out_data.count, out_data.lifetime, out_data.flags,
                          out_data.state, out_data.kind, out_data.size,
                          out_data.address, out_data.status};

endmodule

/* rtl/core/atl_mem.sv */
`timescale 1ns / 1ps

module atl_mem import atl_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
